[hw/rtl/fmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmc_pkg
// Shared types and codes of the fifo mutex coordinator: result status codes,
// action codes and the decision record passed down the pipeline.
// ----------------------------------------------------------------------------
package fmc_pkg;

   // result status codes
   typedef enum logic [2:0] {
      STAT_QUEUED        = 3'd0,
      STAT_GRANTED       = 3'd1,
      STAT_RELEASED_NEXT = 3'd2,
      STAT_RELEASED_IDLE = 3'd3,
      STAT_NOT_HOLDER    = 3'd4,
      STAT_FULL          = 3'd5
   } status_type;

   // action codes of an incoming transaction
   localparam logic ACT_REQUEST = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   // outcome of one transaction as decided by the queue stage
   typedef struct packed {
      logic       grant;
      status_type status;
   } decision_type;

endpackage

[hw/rtl/fmc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmc_queue
// Wait queue of process ids held as a shifting register line: entry 0 is the
// lock holder. Decides the outcome of one registered transaction per cycle
// and updates the queue at the same clock edge.
// ----------------------------------------------------------------------------
module fmc_queue #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8,
   parameter int CNT_W       = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 in_action,
   input  logic [ID_BITS-1:0]   in_id,
   output fmc_pkg::decision_type dec,
   output logic [ID_BITS-1:0]   dec_gid,
   output logic                 dec_holder_valid,
   output logic [ID_BITS-1:0]   dec_holder_id,
   output logic [CNT_W-1:0]     dec_count
);
   import fmc_pkg::*;

   logic [ID_BITS-1:0] queue_ff [QUEUE_DEPTH];
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               push;
   logic               pop;
   decision_type       dec_in;
   logic [ID_BITS-1:0] gid_in;
   logic [ID_BITS-1:0] holder_in;

   // decide request / release outcome
   always_comb begin
      push          = 1'b0;
      pop           = 1'b0;
      dec_in.grant  = 1'b0;
      dec_in.status = STAT_NOT_HOLDER;
      gid_in        = '0;
      if (in_action == ACT_REQUEST) begin
         if (count_ff == '0) begin
            push          = 1'b1;
            dec_in.grant  = 1'b1;
            dec_in.status = STAT_GRANTED;
            gid_in        = in_id;
         end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
            dec_in.status = STAT_FULL;
         end else begin
            push          = 1'b1;
            dec_in.status = STAT_QUEUED;
         end
      end else if (count_ff != '0 && queue_ff[0] == in_id) begin
         pop = 1'b1;
         if (count_ff != CNT_W'(1)) begin
            dec_in.grant  = 1'b1;
            dec_in.status = STAT_RELEASED_NEXT;
            gid_in        = queue_ff[1];
         end else begin
            dec_in.status = STAT_RELEASED_IDLE;
         end
      end
   end

   // occupancy and holder after this transaction
   always_comb begin
      if (push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
      if (count_in == '0) begin
         holder_in = '0;
      end else if (pop) begin
         holder_in = queue_ff[1];
      end else if (count_ff == '0) begin
         holder_in = in_id;
      end else begin
         holder_in = queue_ff[0];
      end
   end

   assign dec              = dec_in;
   assign dec_gid          = gid_in;
   assign dec_holder_valid = (count_in != '0);
   assign dec_holder_id    = holder_in;
   assign dec_count        = count_in;

   // occupancy counter
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (in_valid) begin
         count_ff <= count_in;
      end
   end

   // queue line: shift on release, write at the tail on request
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         if (in_valid && pop) begin
            queue_ff[i] <= queue_ff[i+1];
         end else if (in_valid && push && count_ff == CNT_W'(i)) begin
            queue_ff[i] <= in_id;
         end
      end
      // last slot only ever takes a push
      if (in_valid && push && count_ff == CNT_W'(QUEUE_DEPTH - 1)) begin
         queue_ff[QUEUE_DEPTH-1] <= in_id;
      end
   end

endmodule

[hw/rtl/fmc_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmc_counter
// Per-id saturating grant totals kept in a memory. Looks up the total through a
// registered read, increments and writes it back in the next cycle, with a bypass for
// back to back grants to the same id. Sweeps the memory to zero after reset.
// ----------------------------------------------------------------------------
module fmc_counter #(
   parameter int ID_BITS    = 8,
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  lookup_en,
   input  logic [ID_BITS-1:0]    lookup_id,
   input  logic                  wb_en,
   input  logic [ID_BITS-1:0]    wb_id,
   output logic [COUNT_BITS-1:0] count_next,
   output logic                  clearing
);
   localparam int ID_SPAN = 1 << ID_BITS;

   logic [COUNT_BITS-1:0] totals_ff [ID_SPAN];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  fwd_ff;
   logic [COUNT_BITS-1:0] fwd_val_ff;
   logic                  clear_ff;
   logic [ID_BITS-1:0]    clear_addr_ff;
   logic [COUNT_BITS-1:0] base;

   // saturating increment of the looked up total
   always_comb begin
      base = fwd_ff ? fwd_val_ff : rd_data_ff;
      if (base == '1) begin
         count_next = base;
      end else begin
         count_next = base + COUNT_BITS'(1);
      end
   end

   assign clearing = clear_ff;

   // clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + ID_BITS'(1);
         if (clear_addr_ff == '1) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // totals memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         totals_ff[clear_addr_ff] <= '0;
      end else if (wb_en) begin
         totals_ff[wb_id] <= count_next;
      end
      rd_data_ff <= totals_ff[lookup_id];
   end

   // bypass when the write back and the next lookup hit the same id
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= wb_en && lookup_en && (wb_id == lookup_id);
      end
      fwd_val_ff <= count_next;
   end

endmodule

[hw/rtl/fifo_mutex_coordinator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_mutex_coordinator_core
// FIFO mutual exclusion lock: queues request and release transactions by
// process id, grants the lock in arrival order and counts grants per id.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction (req_action, req_process_id) is taken at a rising edge with
//   start high and busy low. Action request grants at once when the queue is
//   empty, else queues the id (or reports full). Action release from the
//   holder passes the lock to the next waiting id.
//   Each transaction gives exactly one result, shown for one cycle with
//   rsp_valid high; the receiver has no way to hold it off.
//   Path: a transaction passes the input register, the queue stage, the count
//   stage register and the result register before it shows on the rsp_ ports.
//   Throughput: one transaction per cycle when busy is low; the totals memory
//   has one read and one write port and a bypass covers back to back grants.
//   Reset: the queue empties at once; the grant total memory is then swept to
//   zero one entry per cycle, all 2^ID_BITS entries, with busy high throughout.
//   Outside that sweep busy stays low.
// ----------------------------------------------------------------------------
module fifo_mutex_coordinator_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8,
   parameter int COUNT_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_action,
   input  logic [ID_BITS-1:0]                    req_process_id,
   output logic                                  rsp_valid,
   output fmc_pkg::status_type                   rsp_status,
   output logic                                  rsp_grant_valid,
   output logic [ID_BITS-1:0]                    rsp_grant_id,
   output logic [COUNT_BITS-1:0]                 rsp_grant_count,
   output logic                                  rsp_holder_valid,
   output logic [ID_BITS-1:0]                    rsp_holder_id,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]      rsp_waiting_count
);
   import fmc_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic               accept;
   logic               clearing;

   // input register
   logic               in_valid_ff;
   logic               in_action_ff;
   logic [ID_BITS-1:0] in_id_ff;

   // queue stage outputs
   decision_type       dec;
   logic [ID_BITS-1:0] dec_gid;
   logic               dec_holder_valid;
   logic [ID_BITS-1:0] dec_holder_id;
   logic [CNT_W-1:0]   dec_count;

   // count stage registers
   logic               s2_valid_ff;
   decision_type       s2_dec_ff;
   logic [ID_BITS-1:0] s2_gid_ff;
   logic               s2_holder_valid_ff;
   logic [ID_BITS-1:0] s2_holder_id_ff;
   logic [CNT_W-1:0]   s2_count_ff;
   logic [COUNT_BITS-1:0] count_next;

   // result register
   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic                  rsp_grant_valid_ff;
   logic [ID_BITS-1:0]    rsp_grant_id_ff;
   logic [COUNT_BITS-1:0] rsp_grant_count_ff;
   logic                  rsp_holder_valid_ff;
   logic [ID_BITS-1:0]    rsp_holder_id_ff;
   logic [CNT_W-1:0]      rsp_waiting_count_ff;

   assign busy   = clearing;
   assign accept = start && !busy;

   // capture the incoming transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
      in_action_ff <= req_action;
      in_id_ff     <= req_process_id;
   end

   fmc_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS),
      .CNT_W       (CNT_W)
   ) u_queue (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (in_valid_ff),
      .in_action        (in_action_ff),
      .in_id            (in_id_ff),
      .dec              (dec),
      .dec_gid          (dec_gid),
      .dec_holder_valid (dec_holder_valid),
      .dec_holder_id    (dec_holder_id),
      .dec_count        (dec_count)
   );

   fmc_counter #(
      .ID_BITS    (ID_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_counter (
      .clock      (clock),
      .reset      (reset),
      .lookup_en  (in_valid_ff && dec.grant),
      .lookup_id  (dec_gid),
      .wb_en      (s2_valid_ff && s2_dec_ff.grant),
      .wb_id      (s2_gid_ff),
      .count_next (count_next),
      .clearing   (clearing)
   );

   // queue stage to count stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= in_valid_ff;
      end
      s2_dec_ff          <= dec;
      s2_gid_ff          <= dec_gid;
      s2_holder_valid_ff <= dec_holder_valid;
      s2_holder_id_ff    <= dec_holder_id;
      s2_count_ff        <= dec_count;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
      rsp_status_ff        <= s2_dec_ff.status;
      rsp_grant_valid_ff   <= s2_dec_ff.grant;
      rsp_grant_id_ff      <= s2_gid_ff;
      rsp_grant_count_ff   <= s2_dec_ff.grant ? count_next : '0;
      rsp_holder_valid_ff  <= s2_holder_valid_ff;
      rsp_holder_id_ff     <= s2_holder_id_ff;
      rsp_waiting_count_ff <= s2_count_ff;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_grant_valid   = rsp_grant_valid_ff;
   assign rsp_grant_id      = rsp_grant_id_ff;
   assign rsp_grant_count   = rsp_grant_count_ff;
   assign rsp_holder_valid  = rsp_holder_valid_ff;
   assign rsp_holder_id     = rsp_holder_id_ff;
   assign rsp_waiting_count = rsp_waiting_count_ff;

   // every accepted transaction yields its result
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid)
      else $error("result missing three cycles after accept");

   // no result while the grant totals are being cleared
   a_no_rsp_in_clear : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result during clearing sweep");

   // a granted id always has a nonzero total
   a_grant_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_grant_valid) |-> (rsp_grant_count != '0))
      else $error("grant with zero total");

   // holder flag agrees with the occupancy
   a_holder : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_holder_valid == (rsp_waiting_count != '0)))
      else $error("holder flag and queue occupancy disagree");

endmodule

[tb/fifo_mutex_coordinator_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_mutex_coordinator_core_tb
// Self-checking bench for the FIFO mutex coordinator. A class keeps its own
// copy of the wait ring and the per-id grant totals, predicts the result of
// every accepted request or release and matches each rsp_ strobe in order.
// Stimulus: a directed opening, a run of repeated grants to one id, then
// random traffic biased toward holder releases.
// ----------------------------------------------------------------------------
module fifo_mutex_coordinator_core_tb;
   import fmc_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int ID_BITS      = 8;
   localparam int COUNT_BITS   = 16;
   localparam int WAIT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_SPAN      = 1 << ID_BITS;
   localparam int COUNT_MAX    = (1 << COUNT_BITS) - 1;
   localparam int RANDOM_ITEMS = 1780;
   localparam int SAT_ROUNDS   = 24;
   localparam int TAIL_CYCLES  = 8;
   localparam int CYCLE_LIMIT  = 1000000;

   // one predicted result
   typedef struct {
      status_type            status;
      logic                  grant_valid;
      logic [ID_BITS-1:0]    grant_id;
      logic [COUNT_BITS-1:0] grant_count;
      logic                  holder_valid;
      logic [ID_BITS-1:0]    holder_id;
      logic [WAIT_BITS-1:0]  waiting_count;
   } lock_result_type;

   // shadow of the lock queue plus the results still owed by the block
   class lock_queue_model;
      logic [ID_BITS-1:0]    ring [QUEUE_DEPTH];
      int                    head;
      int                    tail;
      int                    entries;
      logic [COUNT_BITS-1:0] totals [ID_SPAN];
      lock_result_type       pending_results [$];
      int                    mismatches;

      function new();
         head       = 0;
         tail       = 0;
         entries    = 0;
         mismatches = 0;
         foreach (ring[i]) ring[i] = '0;
         foreach (totals[i]) totals[i] = '0;
      endfunction

      function void push_id(logic [ID_BITS-1:0] pid);
         ring[tail] = pid;
         tail       = (tail + 1) % QUEUE_DEPTH;
         entries++;
      endfunction

      // predict the result of one accepted transaction
      function void take_transaction(logic act, logic [ID_BITS-1:0] pid);
         lock_result_type    r;
         logic               granted;
         logic [ID_BITS-1:0] gid;
         granted = 1'b0;
         gid     = '0;
         if (act == ACT_REQUEST) begin
            if (entries == 0) begin
               push_id(pid);
               r.status = STAT_GRANTED;
               granted  = 1'b1;
               gid      = pid;
            end else if (entries >= QUEUE_DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               push_id(pid);
               r.status = STAT_QUEUED;
            end
         end else begin
            if (entries == 0 || ring[head] != pid) begin
               r.status = STAT_NOT_HOLDER;
            end else begin
               head = (head + 1) % QUEUE_DEPTH;
               entries--;
               if (entries != 0) begin
                  r.status = STAT_RELEASED_NEXT;
                  granted  = 1'b1;
                  gid      = ring[head];
               end else begin
                  r.status = STAT_RELEASED_IDLE;
               end
            end
         end
         // saturating grant total
         r.grant_count = '0;
         if (granted) begin
            if (totals[gid] != COUNT_BITS'(COUNT_MAX)) totals[gid] = totals[gid] + 1'b1;
            r.grant_count = totals[gid];
         end
         r.grant_valid   = granted;
         r.grant_id      = gid;
         r.holder_valid  = (entries != 0);
         r.holder_id     = (entries != 0) ? ring[head] : '0;
         r.waiting_count = WAIT_BITS'(entries);
         pending_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (act_v !== exp_v) begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            mismatches++;
         end
      endfunction

      // match one observed result against the oldest prediction
      function void match_response(lock_result_type got);
         lock_result_type want;
         if (pending_results.size() == 0) begin
            $error("result with no transaction outstanding");
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("grant_valid", 32'(want.grant_valid), 32'(got.grant_valid));
         compare_field("grant_id", 32'(want.grant_id), 32'(got.grant_id));
         compare_field("grant_count", 32'(want.grant_count), 32'(got.grant_count));
         compare_field("holder_valid", 32'(want.holder_valid), 32'(got.holder_valid));
         compare_field("holder_id", 32'(want.holder_id), 32'(got.holder_id));
         compare_field("waiting_count", 32'(want.waiting_count), 32'(got.waiting_count));
      endfunction
   endclass

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  start          = 1'b0;
   logic                  req_action     = 1'b0;
   logic [ID_BITS-1:0]    req_process_id = '0;
   logic                  busy;
   logic                  rsp_valid;
   status_type            rsp_status;
   logic                  rsp_grant_valid;
   logic [ID_BITS-1:0]    rsp_grant_id;
   logic [COUNT_BITS-1:0] rsp_grant_count;
   logic                  rsp_holder_valid;
   logic [ID_BITS-1:0]    rsp_holder_id;
   logic [WAIT_BITS-1:0]  rsp_waiting_count;

   lock_queue_model lock_model = new();
   int              cycles     = 0;

   fifo_mutex_coordinator_core #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_process_id    (req_process_id),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_grant_valid   (rsp_grant_valid),
      .rsp_grant_id      (rsp_grant_id),
      .rsp_grant_count   (rsp_grant_count),
      .rsp_holder_valid  (rsp_holder_valid),
      .rsp_holder_id     (rsp_holder_id),
      .rsp_waiting_count (rsp_waiting_count)
   );

   // clock generation
   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result monitor, samples the values held before the edge
   always @(posedge clock) begin
      lock_result_type got;
      if (!reset) begin
         if ($isunknown(rsp_valid)) begin
            $error("rsp_valid unknown");
            lock_model.mismatches++;
         end else if (rsp_valid) begin
            got.status        = rsp_status;
            got.grant_valid   = rsp_grant_valid;
            got.grant_id      = rsp_grant_id;
            got.grant_count   = rsp_grant_count;
            got.holder_valid  = rsp_holder_valid;
            got.holder_id     = rsp_holder_id;
            got.waiting_count = rsp_waiting_count;
            lock_model.match_response(got);
         end
      end
   end

   // drive one transaction after an optional idle gap, return once accepted
   task automatic send_item(input int gap, input logic act, input logic [ID_BITS-1:0] pid);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_action     <= act;
      req_process_id <= pid;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      lock_model.take_transaction(act, pid);
   endtask

   initial begin
      int                 req_pct;
      int                 roll;
      int                 gap;
      int                 sat_id;
      bit                 quiet;
      logic               act;
      logic [ID_BITS-1:0] pid;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: release on empty, grant, foreign release, duplicates, handoff
      send_item(0, ACT_RELEASE, 8'h00);
      send_item(0, ACT_REQUEST, 8'hff);
      send_item(1, ACT_RELEASE, 8'h00);
      send_item(0, ACT_REQUEST, 8'h00);
      send_item(2, ACT_REQUEST, 8'hff);
      send_item(0, ACT_RELEASE, 8'hff);
      send_item(0, ACT_RELEASE, 8'h00);
      send_item(3, ACT_RELEASE, 8'hff);
      // fill the ring from empty, then one request too many
      for (int i = 0; i < QUEUE_DEPTH; i++)
         send_item(i % 3, ACT_REQUEST, (i % 2) ? 8'hff : ID_BITS'(i * 17));
      send_item(0, ACT_REQUEST, 8'h5a);

      // drain, then grant one id over and over
      while (lock_model.entries != 0)
         send_item(0, ACT_RELEASE, lock_model.ring[lock_model.head]);
      sat_id = $urandom_range(0, ID_SPAN - 1);
      for (int i = 0; i < SAT_ROUNDS; i++) begin
         send_item(0, ACT_REQUEST, ID_BITS'(sat_id));
         send_item(0, ACT_RELEASE, ID_BITS'(sat_id));
      end

      // random traffic with a changing request/release mix
      req_pct = 50;
      quiet   = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            case ($urandom_range(0, 2))
               0: begin
                  req_pct = 25;
               end
               1: begin
                  req_pct = 50;
               end
               default: begin
                  req_pct = 85;
               end
            endcase
         end
         if (n % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
         // idle gap, mostly short, a few long
         roll = $urandom_range(0, 99);
         if (quiet || roll < 65) gap = 0;
         else if (roll < 95) gap = $urandom_range(1, 3);
         else gap = $urandom_range(10, 30);
         // pick an id: small pool for duplicates, extremes, or anything
         roll = $urandom_range(0, 9);
         if (roll < 4) pid = ID_BITS'($urandom_range(0, 3));
         else if (roll == 4) pid = '1;
         else if (roll == 5) pid = '0;
         else pid = ID_BITS'($urandom_range(0, ID_SPAN - 1));
         // mostly releases from the holder, some from anyone
         if ($urandom_range(0, 99) < req_pct) begin
            act = ACT_REQUEST;
         end else begin
            act = ACT_RELEASE;
            if (lock_model.entries != 0 && $urandom_range(0, 3) != 0)
               pid = lock_model.ring[lock_model.head];
         end
         send_item(gap, act, pid);
      end
      start <= 1'b0;

      // wait for the last results, then keep watching for strays
      while (lock_model.pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (lock_model.mismatches == 0 && lock_model.pending_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/fmc_pkg.sv
hw/rtl/fmc_queue.sv
hw/rtl/fmc_counter.sv
hw/rtl/fifo_mutex_coordinator_core.sv
tb/fifo_mutex_coordinator_core_tb.sv
